// ----- rtl/llq_pkg.sv -----
// Package: request and result payload types, codes and defaults for the linked queue.
package llq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP        = 3'd2;
  localparam logic [2:0] REQ_PEEK       = 3'd3;
  localparam logic [2:0] REQ_SEARCH     = 3'd4;
  localparam logic [2:0] REQ_DELETE     = 3'd5;
  localparam logic [2:0] REQ_CLEAR      = 3'd6;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
    logic [4:0]  length;
  } rsp_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PFREE  = 7'b0000010,
    S_PLINK  = 7'b0000100,
    S_PTAIL  = 7'b0001000,
    S_CUR    = 7'b0010000,
    S_CMP    = 7'b0100000,
    S_DEL    = 7'b1000000
  } state_t;

endpackage

// ----- rtl/llq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module llq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/linked_queue_with_search_delete.sv -----
// Top level: linked-list queue with push, pop, peek, search, delete by match and clear.
// One request is handled at a time and gives one result. Search and delete walk the list
// through the link memory one entry per cycle, until a match or the end of the list.
// Slots never used since the last clear are handed out by a counter, so no clearing pass
// is needed after reset or clear. A new request is taken while the previous result waits,
// as long as that result leaves this cycle.
module linked_queue_with_search_delete #(
  parameter int unsigned DEPTH      = llq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = llq_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  llq_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output llq_pkg::rsp_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  import llq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_t                state_r, state_nxt;
  logic [2:0]            req_r, req_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [31:0]           mask_r;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [AW-1:0]         free_head_r, free_head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         fresh_r, fresh_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [AW-1:0]         prev_r, prev_nxt;
  logic [AW-1:0]         cur_r, cur_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rsp_t                  out_r, out_nxt;

  logic                  lw_en, vw_en;
  logic [AW-1:0]         lw_addr, lr_addr, vr_addr;
  logic [AW-1:0]         lw_data, l_rd;
  logic [DATA_WIDTH-1:0] v_rd;

  logic                  accept, fin, hit;
  logic [1:0]            fin_status;
  logic [31:0]           fin_result;

  llq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .raddr (lr_addr),
    .rdata (l_rd)
  );

  llq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (vw_en),
    .waddr (slot_r),
    .wdata (val_r),
    .raddr (vr_addr),
    .rdata (v_rd)
  );

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign hit = (req_r == REQ_POP) || (req_r == REQ_PEEK) ||
               (((v_rd ^ val_r) & DATA_WIDTH'(mask_r)) == '0);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    val_nxt       = val_r;
    tail_nxt      = tail_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    n_nxt         = n_r;
    slot_nxt      = slot_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    lw_en         = 1'b0;
    vw_en         = 1'b0;
    lw_addr       = slot_r;
    lw_data       = slot_r;
    lr_addr       = tail_r;
    vr_addr       = cur_r;
    fin           = 1'b0;
    fin_status    = STATUS_OK;
    fin_result    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data.req_type;
          val_nxt = DATA_WIDTH'(in_data.value);
          unique case (in_data.req_type) inside
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              if (count_r == CW'(DEPTH)) begin
                fin        = 1'b1;
                fin_status = STATUS_FULL;
              end else if (fresh_r > count_r) begin
                lr_addr   = free_head_r;
                state_nxt = S_PFREE;
              end else begin
                slot_nxt  = fresh_r[AW-1:0];
                fresh_nxt = fresh_r + 1'b1;
                state_nxt = S_PLINK;
              end
            end
            REQ_POP, REQ_PEEK, REQ_SEARCH, REQ_DELETE: begin
              if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = STATUS_EMPTY;
              end else begin
                prev_nxt  = tail_r;
                n_nxt     = '0;
                state_nxt = S_CUR;
              end
            end
            REQ_CLEAR: begin
              count_nxt     = '0;
              fresh_nxt     = '0;
              free_head_nxt = '0;
              tail_nxt      = '0;
              fin           = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_PFREE: begin
        slot_nxt      = free_head_r;
        free_head_nxt = l_rd;
        state_nxt     = S_PLINK;
      end
      S_PLINK: begin
        vw_en   = 1'b1;
        lw_en   = 1'b1;
        lw_data = (count_r == '0) ? slot_r : l_rd;
        if (count_r == '0) begin
          tail_nxt  = slot_r;
          count_nxt = count_r + 1'b1;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PTAIL;
        end
      end
      S_PTAIL: begin
        lw_en   = 1'b1;
        lw_addr = tail_r;
        lw_data = slot_r;
        if (req_r == REQ_PUSH_BACK) begin
          tail_nxt = slot_r;
        end
        count_nxt = count_r + 1'b1;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CUR: begin
        cur_nxt   = l_rd;
        lr_addr   = l_rd;
        vr_addr   = l_rd;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          fin_result = 32'(v_rd);
          if ((req_r == REQ_POP) || (req_r == REQ_DELETE)) begin
            // unlink the entry: predecessor takes over its link
            if (count_r != CW'(1)) begin
              lw_en   = 1'b1;
              lw_addr = prev_r;
              lw_data = l_rd;
            end
            state_nxt = S_DEL;
          end else begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (n_r == CW'(count_r - 1'b1)) begin
          fin        = 1'b1;
          fin_status = STATUS_EMPTY;
          state_nxt  = S_IDLE;
        end else begin
          n_nxt    = n_r + 1'b1;
          prev_nxt = cur_r;
          cur_nxt  = l_rd;
          lr_addr  = l_rd;
          vr_addr  = l_rd;
        end
        if (hit) begin
          out_nxt.result_value = 32'(v_rd);
        end
      end
      S_DEL: begin
        // push the freed slot onto the free list
        lw_en         = 1'b1;
        lw_addr       = cur_r;
        lw_data       = free_head_r;
        free_head_nxt = cur_r;
        count_nxt     = count_r - 1'b1;
        fin           = 1'b1;
        fin_result    = out_r.result_value;
        state_nxt     = S_IDLE;
        if (count_r == CW'(1)) begin
          tail_nxt = '0;
        end else if (cur_r == tail_r) begin
          tail_nxt = prev_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_nxt        = 1'b1;
      out_nxt.status       = fin_status;
      out_nxt.result_value = fin_result;
      out_nxt.length       = 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '1;
      tail_r      <= '0;
      free_head_r <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    val_r  <= val_nxt;
    n_r    <= n_nxt;
    slot_r <= slot_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    out_r  <= out_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n) fresh_r >= count_r)
    else $error("held entries exceed slots ever handed out");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_CMP) |-> (n_r < count_r))
    else $error("walk ran past the held entries");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r != S_IDLE) |-> !out_valid_r || $past(out_valid_r))
    else $error("result raised while a request is still in flight");

endmodule

// ----- tb/tb_linked_queue_with_search_delete.sv -----
// Testbench for the linked queue: directed and random requests checked against a queue model.
`timescale 1ns / 100ps

module tb_linked_queue_with_search_delete;
  import llq_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  logic [31:0] held_words[$];
  logic [31:0] mask_now = 32'hFFFF_FFFF;
  rsp_t        pending_rsp[$];
  int          mismatches = 0;
  bit          calm = 1'b0;

  linked_queue_with_search_delete DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic rsp_t queue_apply(logic [2:0] kind, logic [31:0] word);
    rsp_t r;
    int   hit;
    r = '0;
    hit = -1;
    case (kind)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (held_words.size() >= QDEPTH) r.status = STATUS_FULL;
        else if (kind == REQ_PUSH_BACK) held_words.push_back(word);
        else held_words.push_front(word);
      end
      REQ_POP, REQ_PEEK: begin
        if (held_words.size() == 0) r.status = STATUS_EMPTY;
        else begin
          r.result_value = held_words[0];
          if (kind == REQ_POP) void'(held_words.pop_front());
        end
      end
      REQ_SEARCH, REQ_DELETE: begin
        foreach (held_words[i])
          if (hit < 0 && ((held_words[i] ^ word) & mask_now) == 0) hit = i;
        if (hit < 0) r.status = STATUS_EMPTY;
        else begin
          r.result_value = held_words[hit];
          if (kind == REQ_DELETE) held_words.delete(hit);
        end
      end
      REQ_CLEAR: held_words.delete();
      default: ;
    endcase
    r.length = 5'(held_words.size());
    return r;
  endfunction

  task automatic send_request(logic [2:0] kind, logic [31:0] word);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, value: word};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp.push_back(queue_apply(kind, word));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_mask(logic [31:0] m);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mask_now = m;
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = pending_rsp.pop_front();
        if (e.status !== out_data.status || e.result_value !== out_data.result_value ||
            e.length !== out_data.length) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
      end
    end
  end

  // result-side stalls
  initial begin
    int n;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 19);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic test_directed();
    send_request(REQ_POP, 32'h0);
    send_request(REQ_PEEK, 32'h0);
    send_request(REQ_SEARCH, 32'h1);
    send_request(REQ_DELETE, 32'h1);
    for (int i = 0; i < QDEPTH; i++)
      send_request(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                   i == 0 ? 32'hFFFF_FFFF : 32'(i * 32'h1111_1111));
    send_request(REQ_PUSH_BACK, 32'h5);
    send_request(REQ_PUSH_FRONT, 32'h6);
    send_request(REQ_SEARCH, 32'hFFFF_FFFF);
    send_request(REQ_DELETE, 32'hFFFF_FFFF);
    send_request(REQ_DELETE, 32'h2222_2222);
    send_request(REQ_PEEK, 32'h0);
    send_request(REQ_POP, 32'h0);
    send_request(REQ_UNKNOWN, 32'hA5A5_A5A5);
    send_request(REQ_CLEAR, 32'h0);
    send_request(REQ_PUSH_BACK, 32'h0);
  endtask

  task automatic test_random(int count);
    logic [2:0]  kind;
    logic [31:0] word;
    for (int i = 0; i < count; i++) begin
      kind = 3'($urandom_range(0, 99) < 3 ? REQ_CLEAR : $urandom_range(0, 5));
      if ($urandom_range(0, 99) == 0) kind = REQ_UNKNOWN;
      word = $urandom();
      if (kind inside {REQ_PUSH_BACK, REQ_PUSH_FRONT} && $urandom_range(0, 1))
        word = 32'($urandom_range(0, 7)) | (word & 32'hFFFF_0000);
      if (kind inside {REQ_SEARCH, REQ_DELETE} && held_words.size() != 0 &&
          $urandom_range(0, 2) != 0)
        word = held_words[$urandom_range(0, held_words.size() - 1)] ^
               ($urandom() & ~mask_now);
      send_request(kind, word);
      if (i == count / 2) drain_results();
    end
  endtask

  task automatic test_masks();
    write_mask(32'h0000_0000);
    test_random(150);
    write_mask(32'h0000_FFFF);
    test_random(400);
    write_mask(32'h0000_0007);
    test_random(400);
    write_mask($urandom());
    test_random(300);
    write_mask(32'hFFFF_FFFF);
    test_random(300);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100);
    test_masks();
    calm = 1'b1;
    test_random(150);
    drain_results();
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb_linked_queue_with_search_delete OK");
    end else begin
      $display("tb_linked_queue_with_search_delete NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_linked_queue_with_search_delete NOT OK");
    $finish;
  end

endmodule
